### rtl/seg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_pkg
// Widths, pipeline stage positions and payload types shared by the
// segment intersection block and its interfaces.
// ----------------------------------------------------------------------------
package seg_pkg;

    // coordinate and output formats
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = 24;

    // edge vectors, single products and cross products
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // magnitude of a direction component and of the normalized denominator
    localparam int MAG_W = COORD_BITS;
    localparam int DEN_W = 2 * COORD_BITS + 1;

    // scaled product |dir| * nt * 2^FRAC_BITS and its quotient by den
    localparam int MUL_W      = MAG_W + DEN_W;
    localparam int DIVD_W     = MUL_W + FRAC_BITS;
    localparam int QUO_W      = MAG_W + FRAC_BITS;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = (QUO_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QPAD_W     = DIV_STAGES * DIV_BITS;

    // final add and saturation
    localparam int SUM_W = QPAD_W + 2;
    localparam int SAT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    // pipeline stage positions
    localparam int ST_DIFF  = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_CROSS = 2;
    localparam int ST_NORM  = 3;
    localparam int ST_MUL   = 4;
    localparam int ST_DIV   = 5;
    localparam int ST_SUM   = ST_DIV + DIV_STAGES;
    localparam int ST_OUT   = ST_SUM + 1;
    localparam int NUM_STG  = ST_OUT + 1;
    localparam int CO_STG   = ST_SUM - ST_MUL + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic        [MAG_W-1:0]      mag_t;
    typedef logic        [DEN_W-1:0]      den_t;
    typedef logic signed [OUT_W-1:0]      out_t;
    typedef logic        [CO_STG-1:0]     co_en_t;

endpackage
`default_nettype wire

### rtl/seg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_in_if
// Request channel carrying the endpoints of two segments.
// ----------------------------------------------------------------------------
interface seg_in_if;
    import seg_pkg::*;

    logic   valid;
    logic   ready;
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;

    modport source (
        output valid,
        output first_start_x,
        output first_start_y,
        output first_end_x,
        output first_end_y,
        output second_start_x,
        output second_start_y,
        output second_end_x,
        output second_end_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_start_x,
        input  first_start_y,
        input  first_end_x,
        input  first_end_y,
        input  second_start_x,
        input  second_start_y,
        input  second_end_x,
        input  second_end_y,
        output ready
    );

endinterface
`default_nettype wire

### rtl/seg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_out_if
// Result channel carrying the hit flag and the hit point in fixed point.
// ----------------------------------------------------------------------------
interface seg_out_if;
    import seg_pkg::*;

    logic valid;
    logic ready;
    logic hit;
    out_t hit_x;
    out_t hit_y;

    modport source (
        output valid,
        output hit,
        output hit_x,
        output hit_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit,
        input  hit_x,
        input  hit_y,
        output ready
    );

endinterface
`default_nettype wire

### rtl/seg_coord.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seg_coord
// One output coordinate: base * 2^F + sign * trunc(|dir| * nt * 2^F / den).
// Multiply stage, restoring divider with DIV_BITS quotient bits per stage,
// then add and saturate. Each stage loads on its own enable.
// ----------------------------------------------------------------------------
module seg_coord (
    input  logic            clk,
    input  seg_pkg::co_en_t en,
    input  seg_pkg::coord_t base,
    input  seg_pkg::mag_t   mag,
    input  logic            neg,
    input  seg_pkg::den_t   num,
    input  seg_pkg::den_t   den,
    output seg_pkg::out_t   coord
);
    import seg_pkg::*;

    localparam longint LIM_HI_L = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint LIM_LO_L = -(longint'(1) << (OUT_W - 1));
    localparam logic signed [SAT_W-1:0] LIM_HI = SAT_W'(LIM_HI_L);
    localparam logic signed [SAT_W-1:0] LIM_LO = SAT_W'(LIM_LO_L);

    // multiply stage
    logic [MUL_W-1:0] prod_reg;
    den_t             mden_reg;
    coord_t           mbase_reg;
    logic             mneg_reg;

    // divider stages
    den_t              rem_reg   [DIV_STAGES];
    logic [QPAD_W-1:0] wq_reg    [DIV_STAGES];
    den_t              dden_reg  [DIV_STAGES];
    coord_t            dbase_reg [DIV_STAGES];
    logic              dneg_reg  [DIV_STAGES];

    den_t              rem_src   [DIV_STAGES];
    logic [QPAD_W-1:0] wq_src    [DIV_STAGES];
    den_t              den_src   [DIV_STAGES];
    coord_t            base_src  [DIV_STAGES];
    logic              neg_src   [DIV_STAGES];
    den_t              rem_next  [DIV_STAGES];
    logic [QPAD_W-1:0] wq_next   [DIV_STAGES];

    logic [DIVD_W-1:0] divd;

    // sum stage
    logic signed [SUM_W-1:0] base_sc;
    logic signed [SUM_W-1:0] quo_sc;
    logic signed [SUM_W-1:0] sum;
    logic signed [SAT_W-1:0] sum_ext;
    out_t                    coord_next;
    out_t                    coord_reg;

    // |dir| * nt
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= MUL_W'(mag) * MUL_W'(num);
            mden_reg  <= den;
            mbase_reg <= base;
            mneg_reg  <= neg;
        end
    end

    // scaled dividend split into the first partial remainder and the bits to come
    assign divd = DIVD_W'(prod_reg) << FRAC_BITS;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_div
            // stage inputs
            if (g == 0)
            begin : g_first
                assign rem_src[g]  = DEN_W'(divd[DIVD_W-1:QPAD_W]);
                assign wq_src[g]   = divd[QPAD_W-1:0];
                assign den_src[g]  = mden_reg;
                assign base_src[g] = mbase_reg;
                assign neg_src[g]  = mneg_reg;
            end
            else
            begin : g_rest
                assign rem_src[g]  = rem_reg[g-1];
                assign wq_src[g]   = wq_reg[g-1];
                assign den_src[g]  = dden_reg[g-1];
                assign base_src[g] = dbase_reg[g-1];
                assign neg_src[g]  = dneg_reg[g-1];
            end

            // restoring steps, quotient bits shift in at the bottom
            always_comb
            begin
                den_t              r;
                logic [QPAD_W-1:0] w;
                logic [DEN_W:0]    t;
                r = rem_src[g];
                w = wq_src[g];
                t = '0;
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    t = {r, w[QPAD_W-1]};
                    if (t >= {1'b0, den_src[g]})
                    begin
                        r = DEN_W'(t - {1'b0, den_src[g]});
                        w = {w[QPAD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[DEN_W-1:0];
                        w = {w[QPAD_W-2:0], 1'b0};
                    end
                end
                rem_next[g] = r;
                wq_next[g]  = w;
            end

            always_ff @(posedge clk)
            begin
                if (en[g+1])
                begin
                    rem_reg[g]   <= rem_next[g];
                    wq_reg[g]    <= wq_next[g];
                    dden_reg[g]  <= den_src[g];
                    dbase_reg[g] <= base_src[g];
                    dneg_reg[g]  <= neg_src[g];
                end
            end
        end
    endgenerate

    // base plus signed quotient, clipped to the output range
    always_comb
    begin
        base_sc = SUM_W'(dbase_reg[DIV_STAGES-1]) <<< FRAC_BITS;
        quo_sc  = $signed(SUM_W'(wq_reg[DIV_STAGES-1]));
        sum     = dneg_reg[DIV_STAGES-1] ? (base_sc - quo_sc) : (base_sc + quo_sc);
        sum_ext = SAT_W'(sum);
        if (sum_ext > LIM_HI)
        begin
            coord_next = OUT_W'(LIM_HI);
        end
        else if (sum_ext < LIM_LO)
        begin
            coord_next = OUT_W'(LIM_LO);
        end
        else
        begin
            coord_next = OUT_W'(sum_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[CO_STG-1])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule
`default_nettype wire

### rtl/segment_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection
// Exact 2-D intersection test of segment A-B against segment C-D with the
// hit point A + r*nt/den returned in signed Q.8 fixed point.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock while the output is not held
// off, and returns one result per pair, in order. The pipeline depth is set
// by the 24-bit quotient t*|r|*256 (t = nt/den), which a restoring
// divider resolves two bits per stage over twelve stages, ahead of which sit
// the edge vectors, the six 17x17 products, the cross products, the sign
// normalization and the |r|*nt multiply, and after which the add, clip and
// output register follow. Every stage loads on its own enable, so a held-off
// output stalls only as far back as the pipeline is full and empty slots
// are filled while it waits. A miss (parallel, collinear or disjoint) gives
// hit = 0 with both coordinates zero; endpoint contact counts as a hit.
// ----------------------------------------------------------------------------
module segment_intersection (
    input  logic        clk,
    input  logic        rst_n,
    seg_in_if.sink      segs,
    seg_out_if.source   result
);
    import seg_pkg::*;

    // stage handshake
    logic [NUM_STG-1:0] valid_reg;
    logic [NUM_STG-1:0] valid_next;
    logic [NUM_STG-1:0] en;

    // edge vectors
    coord_t ax0_reg, ay0_reg;
    diff_t  rx0_reg, ry0_reg, sx0_reg, sy0_reg, qx0_reg, qy0_reg;

    // single products
    prod_t  den_a_reg, den_b_reg, nt_a_reg, nt_b_reg, nu_a_reg, nu_b_reg;
    coord_t ax1_reg, ay1_reg;
    diff_t  rx1_reg, ry1_reg;

    // cross products
    cross_t den_reg, nt_reg, nu_reg;
    coord_t ax2_reg, ay2_reg;
    diff_t  rx2_reg, ry2_reg;

    // normalized
    den_t   den_abs_reg;
    cross_t nt_n_reg, nu_n_reg;
    logic   den_zero_reg;
    mag_t   magx_reg, magy_reg;
    logic   negx_reg, negy_reg;
    coord_t ax3_reg, ay3_reg;
    logic   flip;

    // hit flag alongside the coordinate pipes
    logic   hit_next;
    cross_t den_cmp;
    logic   hit_line_reg [CO_STG];

    out_t   coord_x, coord_y;
    logic   hit_reg;
    out_t   hit_x_reg, hit_y_reg;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[NUM_STG-1] = !valid_reg[NUM_STG-1] || result.ready;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign segs.ready = en[0];

    // valid bits follow the data
    always_comb
    begin
        valid_next[0] = en[0] ? segs.valid : valid_reg[0];
        for (int k = 1; k < NUM_STG; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // r = B-A, s = D-C, q = C-A
    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            ax0_reg <= segs.first_start_x;
            ay0_reg <= segs.first_start_y;
            rx0_reg <= DIFF_W'(segs.first_end_x) - DIFF_W'(segs.first_start_x);
            ry0_reg <= DIFF_W'(segs.first_end_y) - DIFF_W'(segs.first_start_y);
            sx0_reg <= DIFF_W'(segs.second_end_x) - DIFF_W'(segs.second_start_x);
            sy0_reg <= DIFF_W'(segs.second_end_y) - DIFF_W'(segs.second_start_y);
            qx0_reg <= DIFF_W'(segs.second_start_x) - DIFF_W'(segs.first_start_x);
            qy0_reg <= DIFF_W'(segs.second_start_y) - DIFF_W'(segs.first_start_y);
        end
    end

    // products for the three cross products
    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            den_a_reg <= PROD_W'(rx0_reg) * PROD_W'(sy0_reg);
            den_b_reg <= PROD_W'(ry0_reg) * PROD_W'(sx0_reg);
            nt_a_reg  <= PROD_W'(qx0_reg) * PROD_W'(sy0_reg);
            nt_b_reg  <= PROD_W'(qy0_reg) * PROD_W'(sx0_reg);
            nu_a_reg  <= PROD_W'(qx0_reg) * PROD_W'(ry0_reg);
            nu_b_reg  <= PROD_W'(qy0_reg) * PROD_W'(rx0_reg);
            ax1_reg   <= ax0_reg;
            ay1_reg   <= ay0_reg;
            rx1_reg   <= rx0_reg;
            ry1_reg   <= ry0_reg;
        end
    end

    // den = r x s, nt = q x s, nu = q x r
    always_ff @(posedge clk)
    begin
        if (en[ST_CROSS])
        begin
            den_reg <= CROSS_W'(den_a_reg) - CROSS_W'(den_b_reg);
            nt_reg  <= CROSS_W'(nt_a_reg) - CROSS_W'(nt_b_reg);
            nu_reg  <= CROSS_W'(nu_a_reg) - CROSS_W'(nu_b_reg);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            rx2_reg <= rx1_reg;
            ry2_reg <= ry1_reg;
        end
    end

    // flip signs so den is positive, split r into magnitude and sign
    assign flip = den_reg[CROSS_W-1];

    always_ff @(posedge clk)
    begin
        if (en[ST_NORM])
        begin
            den_abs_reg  <= DEN_W'(flip ? -den_reg : den_reg);
            nt_n_reg     <= flip ? -nt_reg : nt_reg;
            nu_n_reg     <= flip ? -nu_reg : nu_reg;
            den_zero_reg <= (den_reg == '0);
            magx_reg     <= MAG_W'(rx2_reg[DIFF_W-1] ? -rx2_reg : rx2_reg);
            magy_reg     <= MAG_W'(ry2_reg[DIFF_W-1] ? -ry2_reg : ry2_reg);
            negx_reg     <= rx2_reg[DIFF_W-1];
            negy_reg     <= ry2_reg[DIFF_W-1];
            ax3_reg      <= ax2_reg;
            ay3_reg      <= ay2_reg;
        end
    end

    // both parameters in the closed unit interval
    always_comb
    begin
        den_cmp  = $signed(CROSS_W'(den_abs_reg));
        hit_next = !den_zero_reg
                   && !nt_n_reg[CROSS_W-1] && (nt_n_reg <= den_cmp)
                   && !nu_n_reg[CROSS_W-1] && (nu_n_reg <= den_cmp);
    end

    genvar h;
    generate
        for (h = 0; h < CO_STG; h++)
        begin : g_hit
            always_ff @(posedge clk)
            begin
                if (en[ST_MUL+h])
                begin
                    if (h == 0)
                    begin
                        hit_line_reg[h] <= hit_next;
                    end
                    else
                    begin
                        hit_line_reg[h] <= hit_line_reg[(h == 0) ? 0 : h-1];
                    end
                end
            end
        end
    endgenerate

    // coordinate pipes
    seg_coord u_coord_x (
        .clk   (clk),
        .en    (en[ST_MUL +: CO_STG]),
        .base  (ax3_reg),
        .mag   (magx_reg),
        .neg   (negx_reg),
        .num   (nt_n_reg[DEN_W-1:0]),
        .den   (den_abs_reg),
        .coord (coord_x)
    );

    seg_coord u_coord_y (
        .clk   (clk),
        .en    (en[ST_MUL +: CO_STG]),
        .base  (ay3_reg),
        .mag   (magy_reg),
        .neg   (negy_reg),
        .num   (nt_n_reg[DEN_W-1:0]),
        .den   (den_abs_reg),
        .coord (coord_y)
    );

    // output register, coordinates zero on a miss
    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            hit_reg   <= hit_line_reg[CO_STG-1];
            hit_x_reg <= hit_line_reg[CO_STG-1] ? coord_x : '0;
            hit_y_reg <= hit_line_reg[CO_STG-1] ? coord_y : '0;
        end
    end

    assign result.valid = valid_reg[ST_OUT];
    assign result.hit   = hit_reg;
    assign result.hit_x = hit_x_reg;
    assign result.hit_y = hit_y_reg;

endmodule
`default_nettype wire

### tb/sv/segment_intersection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_test
// Self-checking bench for the segment intersection pipeline. A queue of
// segment pairs feeds a bursty driver while the result side stalls on its
// own pattern. Every accepted request is predicted in exact 64-bit integer
// math, and each result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module segment_intersection_test;
    import seg_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 40;
    localparam int RANDOM_PAIRS = 1300;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 160;

    typedef struct {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
        coord_t dx;
        coord_t dy;
        bit     hold_until_idle;
    } seg_pair_t;

    typedef struct {
        logic hit;
        out_t hit_x;
        out_t hit_y;
    } crossing_t;

    typedef enum int {
        ALWAYS_READY,
        MOSTLY_READY,
        RARELY_READY,
        TWO_OF_FIVE
    } stall_mode_t;

    logic clk;
    logic rst_n;

    seg_in_if  pair_if ();
    seg_out_if crossing_if ();

    segment_intersection dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .segs   (pair_if),
        .result (crossing_if)
    );

    seg_pair_t queued_pairs[$];
    crossing_t awaited_crossings[$];
    int        mismatch_count;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // one coordinate of A + r*nt/den in fixed point, quotient truncated toward zero
    function automatic out_t scale_along(longint base, longint dir, longint num, longint den);
        longint unsigned mag;
        longint unsigned num_u;
        longint unsigned den_u;
        longint unsigned quo;
        longint          pos;
        longint          lim_hi;
        longint          lim_lo;
        mag   = (dir < 0) ? -dir : dir;
        num_u = num;
        den_u = den;
        quo   = ((mag * num_u) << FRAC_BITS) / den_u;
        pos   = base * (longint'(1) << FRAC_BITS) + ((dir < 0) ? -longint'(quo) : longint'(quo));
        lim_hi = (longint'(1) << (OUT_W - 1)) - 1;
        lim_lo = -(longint'(1) << (OUT_W - 1));
        if (pos > lim_hi)
            pos = lim_hi;
        if (pos < lim_lo)
            pos = lim_lo;
        return out_t'(pos);
    endfunction

    // exact crossing test of A-B against C-D
    function automatic crossing_t crossing_point(seg_pair_t p);
        longint    ax, ay, bx, by, cx, cy, dx, dy;
        longint    rx, ry, sx, sy, qx, qy;
        longint    den, nt, nu;
        crossing_t res;
        ax = p.ax;
        ay = p.ay;
        bx = p.bx;
        by = p.by;
        cx = p.cx;
        cy = p.cy;
        dx = p.dx;
        dy = p.dy;
        rx = bx - ax;
        ry = by - ay;
        sx = dx - cx;
        sy = dy - cy;
        qx = cx - ax;
        qy = cy - ay;
        den = rx * sy - ry * sx;
        nt  = qx * sy - qy * sx;
        nu  = qx * ry - qy * rx;
        res.hit   = 1'b0;
        res.hit_x = '0;
        res.hit_y = '0;
        // parallel, collinear or point segments never hit
        if (den != 0)
        begin
            if (den < 0)
            begin
                den = -den;
                nt  = -nt;
                nu  = -nu;
            end
            if (nt >= 0 && nt <= den && nu >= 0 && nu <= den)
            begin
                res.hit   = 1'b1;
                res.hit_x = scale_along(ax, rx, nt, den);
                res.hit_y = scale_along(ay, ry, nt, den);
            end
        end
        return res;
    endfunction

    function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = coord_t'(ax);
        p.ay = coord_t'(ay);
        p.bx = coord_t'(bx);
        p.by = coord_t'(by);
        p.cx = coord_t'(cx);
        p.cy = coord_t'(cy);
        p.dx = coord_t'(dx);
        p.dy = coord_t'(dy);
        p.hold_until_idle = 1'b0;
        return p;
    endfunction

    // append a pair at the tail of the stimulus queue
    function automatic void queue_pair(seg_pair_t p);
        queued_pairs = {queued_pairs, p};
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // random pair, mostly built to cross or to sit on a common line
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        kind;
        int        m, px, py, r1x, r1y, r2x, r2y, ox, oy, n;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            // full range, every bit free
            p = make_pair($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
        end
        else if (kind < 70)
        begin
            // two segments through a common point, endpoints pulled in by eighths
            case ($urandom_range(2))
                0: m = 4;
                1: m = 300;
                default: m = 16000;
            endcase
            px  = spread(16000);
            py  = spread(16000);
            r1x = spread(m);
            r1y = spread(m);
            r2x = spread(m);
            r2y = spread(m);
            p = make_pair(px - r1x * int'($urandom_range(8)) / 8,
                          py - r1y * int'($urandom_range(8)) / 8,
                          px + r1x * int'($urandom_range(8)) / 8,
                          py + r1y * int'($urandom_range(8)) / 8,
                          px - r2x * int'($urandom_range(8)) / 8,
                          py - r2y * int'($urandom_range(8)) / 8,
                          px + r2x * int'($urandom_range(8)) / 8,
                          py + r2y * int'($urandom_range(8)) / 8);
        end
        else if (kind < 85)
        begin
            // tiny grid, rich in touches and collinear overlaps
            p = make_pair(spread(4), spread(4), spread(4), spread(4),
                          spread(4), spread(4), spread(4), spread(4));
        end
        else
        begin
            // parallel or collinear pair
            px  = spread(10000);
            py  = spread(10000);
            r1x = spread(1000);
            r1y = spread(1000);
            n   = spread(2);
            if ($urandom_range(1) == 0)
            begin
                ox = 0;
                oy = 0;
            end
            else
            begin
                ox = spread(10000);
                oy = spread(10000);
            end
            p = make_pair(px, py, px + r1x, py + r1y,
                          px + ox, py + oy, px + ox + n * r1x, py + oy + n * r1y);
        end
        return p;
    endfunction

    // request driver: bursts of random length with random gaps
    seg_pair_t cur_pair;
    int        burst_left;
    int        gap_left;

    always @(posedge clk or negedge rst_n)
    begin : drive_pairs
        logic offer;
        if (!rst_n)
        begin
            pair_if.valid          <= 1'b0;
            pair_if.first_start_x  <= '0;
            pair_if.first_start_y  <= '0;
            pair_if.first_end_x    <= '0;
            pair_if.first_end_y    <= '0;
            pair_if.second_start_x <= '0;
            pair_if.second_start_y <= '0;
            pair_if.second_end_x   <= '0;
            pair_if.second_end_y   <= '0;
            burst_left             <= 1;
            gap_left               <= 0;
        end
        else
        begin
            offer = pair_if.valid;
            // accepted request: record its prediction
            if (pair_if.valid && pair_if.ready)
            begin
                awaited_crossings = {awaited_crossings, crossing_point(cur_pair)};
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (queued_pairs.size() > 0 &&
                         (!queued_pairs[0].hold_until_idle || awaited_crossings.size() == 0))
                begin
                    cur_pair = queued_pairs.pop_front();
                    pair_if.first_start_x  <= cur_pair.ax;
                    pair_if.first_start_y  <= cur_pair.ay;
                    pair_if.first_end_x    <= cur_pair.bx;
                    pair_if.first_end_y    <= cur_pair.by;
                    pair_if.second_start_x <= cur_pair.cx;
                    pair_if.second_start_y <= cur_pair.cy;
                    pair_if.second_end_x   <= cur_pair.dx;
                    pair_if.second_end_y   <= cur_pair.dy;
                    offer = 1'b1;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            pair_if.valid <= offer;
        end
    end

    // result side stall pattern plus one long hold-off
    stall_mode_t stall_mode;
    int          mode_left;
    int          hold_left;
    int          results_seen;
    int          pace_phase;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin : pace_results
        logic take;
        if (!rst_n)
        begin
            crossing_if.ready <= 1'b0;
            stall_mode        <= ALWAYS_READY;
            mode_left         <= 0;
            hold_left         <= 0;
            results_seen      <= 0;
            pace_phase        <= 0;
            hold_done         <= 1'b0;
        end
        else
        begin
            if (crossing_if.valid && crossing_if.ready)
                results_seen <= results_seen + 1;
            pace_phase <= (pace_phase == 4) ? 0 : pace_phase + 1;
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(3));
                mode_left  <= $urandom_range(64, 256);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                ALWAYS_READY: take = 1'b1;
                MOSTLY_READY: take = ($urandom_range(3) != 0);
                RARELY_READY: take = ($urandom_range(3) == 0);
                default:      take = (pace_phase < 2);
            endcase
            // long hold-off so the pipeline fills and stalls its input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                take = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                take = 1'b0;
            end
            crossing_if.ready <= take;
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_crossings
        crossing_t want;
        if (rst_n && crossing_if.valid && crossing_if.ready)
        begin
            if (awaited_crossings.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result: hit=%0b x=%0d y=%0d",
                             crossing_if.hit, crossing_if.hit_x, crossing_if.hit_y);
            end
            else
            begin
                want = awaited_crossings.pop_front();
                if (crossing_if.hit !== want.hit || crossing_if.hit_x !== want.hit_x ||
                    crossing_if.hit_y !== want.hit_y)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display({"result differs: expected hit=%0b x=%0d y=%0d,",
                                  " got hit=%0b x=%0d y=%0d"},
                                 want.hit, want.hit_x, want.hit_y,
                                 crossing_if.hit, crossing_if.hit_x, crossing_if.hit_y);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (pair_if.valid && pair_if.ready) ||
            (crossing_if.valid && crossing_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("segment_intersection: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and end of run
    initial
    begin : run_pairs
        seg_pair_t p;
        // known values before the first edge
        pair_if.valid          = 1'b0;
        pair_if.first_start_x  = '0;
        pair_if.first_start_y  = '0;
        pair_if.first_end_x    = '0;
        pair_if.first_end_y    = '0;
        pair_if.second_start_x = '0;
        pair_if.second_start_y = '0;
        pair_if.second_end_x   = '0;
        pair_if.second_end_y   = '0;
        crossing_if.ready      = 1'b0;
        mismatch_count         = 0;
        idle_cycles            = 0;
        rst_n                  = 1'b0;

        // directed pairs: extremes and the named corner cases
        queue_pair(make_pair(-32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768));
        queue_pair(make_pair(32767, 32767, 32767, 32767,
                             32767, 32767, 32767, 32767));
        queue_pair(make_pair(-32768, -32768, 32767, 32767,
                             -32768, 32767, 32767, -32768));
        queue_pair(make_pair(-32768, 32767, 32767, -32768,
                             -32768, -32768, 32767, 32767));
        queue_pair(make_pair(32767, -32768, -32768, 32767,
                             -32768, -32768, 32767, 32767));
        queue_pair(make_pair(21845, -21846, -21846, 21845,
                             21845, 21845, -21846, -21846));
        // parallel
        queue_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        // collinear overlap
        queue_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        // point segment lying on the other one
        queue_pair(make_pair(3, 0, 3, 0, 0, 0, 10, 0));
        // touching at end points
        queue_pair(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
        queue_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
        // t-junction at the start of the second segment
        queue_pair(make_pair(-5, 0, 5, 0, 0, 0, 0, 10));
        // just past the end of the first segment
        queue_pair(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        // lines cross outside the second segment, on both sides
        queue_pair(make_pair(0, -5, 0, 5, 1, 0, 10, 0));
        queue_pair(make_pair(0, -5, 0, 5, -10, 0, -1, 0));
        // fractional hit points, truncation toward zero on negative directions
        queue_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        queue_pair(make_pair(0, 0, -7, -3, -7, 0, 0, -3));
        queue_pair(make_pair(0, 0, 7, 0, 1, -1, 1, 2));
        queue_pair(make_pair(5, 5, -5, -5, -5, 5, 5, -5));
        queue_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));

        // random pairs, with pauses until the pipeline has drained
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            p = random_pair();
            if (i == 0 || i == 650 || i == 1000)
                p.hold_until_idle = 1'b1;
            queue_pair(p);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all requests to go in and all results to come back
        while (queued_pairs.size() > 0 || pair_if.valid || awaited_crossings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && awaited_crossings.size() == 0)
            $display("segment_intersection: match");
        else
            $display("segment_intersection: mismatch");
        $finish;
    end

endmodule
